// ===== hdl/warning_message_priority_manager_top_assert.svh =====
// Assertion macros shared by the warning message priority manager.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef WARNING_MESSAGE_PRIORITY_MANAGER_TOP_ASSERT_SVH
`define WARNING_MESSAGE_PRIORITY_MANAGER_TOP_ASSERT_SVH

// Same-cycle implication.
`define WMPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WMPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/wmpm_pkg.sv =====
package wmpm_pkg;

  // Fixed sizes of the block.
  localparam int MESSAGES   = 8;
  localparam int LAYOUTS    = 8;
  localparam int CYCLE_TIME = 10;
  localparam int TIMER_W    = 16;
  localparam int ALLOW_W    = 8;
  localparam int SLOT_W     = 3;
  localparam int LAY_SEL_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Timer load offset and per-tick decrement.
  localparam logic [TIMER_W-1:0] TMR_LEAD = TIMER_W'(2 * CYCLE_TIME);
  localparam logic [TIMER_W-1:0] TMR_STEP = TIMER_W'(CYCLE_TIME);

  // Layout code that means no layout.
  localparam logic [3:0] LAYOUT_NONE = 4'hF;

  // Per-message state.
  typedef enum logic [2:0] {
    ST_INACTIVE    = 3'd0,
    ST_ACTIVE      = 3'd1,
    ST_BTN_CLEARED = 3'd2,
    ST_TMR_RUNNING = 3'd3,
    ST_TMR_DONE    = 3'd4,
    ST_CLEARED     = 3'd5
  } msg_state_t;

  // Clear mode of a message.
  typedef enum logic [1:0] {
    CLR_TRIGGER = 2'd0,
    CLR_TIMEOUT = 2'd1,
    CLR_BUTTON  = 2'd2,
    CLR_NONE    = 2'd3
  } clr_mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLEAR_MODES    = 3'd0,
    CFG_RECURRING_MASK = 3'd1,
    CFG_TIMEOUTS_LOW   = 3'd2,
    CFG_TIMEOUTS_HIGH  = 3'd3,
    CFG_LAYOUT_ALLOW   = 3'd4
  } cfg_idx_t;

  // Control broadcast from the top level to every lane.
  typedef struct packed {
    logic                 step;
    logic                 clear_all;
    logic                 layout_ok;
    logic [LAY_SEL_W-1:0] layout_sel;
    logic                 button;
  } lane_ctl_t;

  // Shown message after a tick, produced by the merge stage.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic              changed;
  } merge_res_t;

endpackage

// ===== hdl/wmpm_in_if.sv =====
interface wmpm_in_if;
  import wmpm_pkg::*;

  logic              valid;
  logic              ready;
  logic              ignition_on;
  logic signed [3:0] layout_id;
  logic [7:0]        trigger_mask;
  logic              clear_button;

  modport source (output valid, ignition_on, layout_id, trigger_mask, clear_button,
                  input ready);
  modport sink (input valid, ignition_on, layout_id, trigger_mask, clear_button,
                output ready);
endinterface

// ===== hdl/wmpm_out_if.sv =====
interface wmpm_out_if;
  import wmpm_pkg::*;

  logic              valid;
  logic              ready;
  logic              showing;
  logic [SLOT_W-1:0] shown_index;
  logic              display_changed;
  logic              running;

  modport source (output valid, showing, shown_index, display_changed, running,
                  input ready);
  modport sink (input valid, showing, shown_index, display_changed, running,
                output ready);
endinterface

// ===== hdl/wmpm_cfg_if.sv =====
interface wmpm_cfg_if;
  import wmpm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/warning_message_priority_manager_top.sv =====
// Result: a result is registered and is valid in the cycle after its tick request is accepted.
// Throughput: one tick per cycle; all eight message lanes and the priority
// merge evaluate combinationally in the accepting cycle, and the result register
// frees as it is taken, so input ready stalls only while a result waits.
// Reset: rst_n is synchronous and active low; it stops run mode, sets every
// message inactive, clears the shown message and the registers, and empties the output.
module warning_message_priority_manager_top
  import wmpm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  wmpm_in_if.sink    in_ch,
  wmpm_out_if.source out_ch,
  wmpm_cfg_if.sink   cfg_ch
);

`include "warning_message_priority_manager_top_assert.svh"

  // Configuration registers.
  logic [2*MESSAGES-1:0]  clear_modes_r;
  logic [MESSAGES-1:0]    recurring_mask_r;
  logic [CFG_DATA_W-1:0]  timeouts_low_r;
  logic [CFG_DATA_W-1:0]  timeouts_high_r;
  logic [CFG_DATA_W-1:0]  layout_allow_r;

  logic                   run_mode_r, run_mode_nxt;
  logic                   out_valid_r;
  logic                   out_showing_r;
  logic [SLOT_W-1:0]      out_index_r;
  logic                   out_changed_r;
  logic                   out_running_r;

  logic                   in_acc;
  logic [3:0]             lay_raw;
  logic [3:0]             lay_mag;
  lane_ctl_t              ctl;
  logic [MESSAGES-1:0]    show;
  merge_res_t             res;
  logic [2*CFG_DATA_W-1:0] timeouts_all;

  assign cfg_ch.ready = 1'b1;

  // Configuration write decode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_modes_r    <= '0;
      recurring_mask_r <= '0;
      timeouts_low_r   <= '0;
      timeouts_high_r  <= '0;
      layout_allow_r   <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_CLEAR_MODES:    clear_modes_r    <= cfg_ch.data[2*MESSAGES-1:0];
        CFG_RECURRING_MASK: recurring_mask_r <= cfg_ch.data[MESSAGES-1:0];
        CFG_TIMEOUTS_LOW:   timeouts_low_r   <= cfg_ch.data;
        CFG_TIMEOUTS_HIGH:  timeouts_high_r  <= cfg_ch.data;
        CFG_LAYOUT_ALLOW:   layout_allow_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // A new tick is taken whenever the result register is free or draining.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Layout magnitude; a negative layout uses its magnitude.
  assign lay_raw = in_ch.layout_id;
  assign lay_mag = lay_raw[3] ? 4'(5'd16 - {1'b0, lay_raw}) : lay_raw;

  // Lane control for this tick.
  always_comb begin
    ctl.step       = in_acc && run_mode_r && in_ch.ignition_on;
    ctl.clear_all  = in_acc && !run_mode_r && in_ch.ignition_on;
    ctl.layout_ok  = (lay_raw != LAYOUT_NONE) && !lay_mag[3] && (int'(lay_mag) < LAYOUTS);
    ctl.layout_sel = lay_mag[LAY_SEL_W-1:0];
    ctl.button     = in_ch.clear_button;
  end

  // Run mode follows ignition on each accepted tick.
  assign run_mode_nxt = in_acc ? in_ch.ignition_on : run_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_mode_r <= 1'b0;
    end else begin
      run_mode_r <= run_mode_nxt;
    end
  end

  assign timeouts_all = {timeouts_high_r, timeouts_low_r};

  // One lane per message.
  for (genvar m = 0; m < MESSAGES; m++) begin : g_lane
    wmpm_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .trig    (in_ch.trigger_mask[m]),
      .rec     (recurring_mask_r[m]),
      .mode    (clr_mode_t'(clear_modes_r[2*m +: 2])),
      .timeout (timeouts_all[TIMER_W*m +: TIMER_W]),
      .allow   (layout_allow_r[ALLOW_W*m +: ALLOW_W]),
      .show    (show[m])
    );
  end

  // Priority merge across lanes.
  wmpm_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (ctl.step),
    .show  (show),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_showing_r <= res.valid;
      out_index_r   <= res.slot;
      out_changed_r <= res.changed;
      out_running_r <= run_mode_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.showing         = out_showing_r;
  assign out_ch.shown_index     = out_index_r;
  assign out_ch.display_changed = out_changed_r;
  assign out_ch.running         = out_running_r;

  // Checks on the tick sequencing.
  `WMPM_ASSERT_NEXT(a_result_follows_tick, in_acc, out_valid_r, "no result after an accepted tick")
  `WMPM_ASSERT_NEXT(a_no_change_when_off, in_acc && !run_mode_r, !out_changed_r, "display change reported outside run mode")
  `WMPM_ASSERT_NOW(a_index_zero_when_blank, out_valid_r && !out_showing_r, out_index_r == '0, "index nonzero with nothing shown")
  `WMPM_ASSERT_NOW(a_running_matches_mode, out_valid_r, out_running_r == run_mode_r, "reported run mode differs from run mode")

endmodule

// ===== hdl/wmpm_lane.sv =====
module wmpm_lane
  import wmpm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  lane_ctl_t          ctl,
  input  logic               trig,
  input  logic               rec,
  input  clr_mode_t          mode,
  input  logic [TIMER_W-1:0] timeout,
  input  logic [ALLOW_W-1:0] allow,
  output logic               show
);

  msg_state_t         state_r, state_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic               allowed;

  assign allowed = ctl.layout_ok && allow[ctl.layout_sel];

  // Next state and timer of this message.
  always_comb begin
    state_nxt = state_r;
    timer_nxt = timer_r;
    unique case (state_r)
      ST_INACTIVE: begin
        if (allowed && trig) state_nxt = ST_ACTIVE;
      end
      ST_ACTIVE: begin
        case (mode)
          CLR_TRIGGER: begin
            if (!trig) state_nxt = ST_INACTIVE;
          end
          CLR_TIMEOUT: begin
            timer_nxt = (timeout > TMR_LEAD) ? timeout - TMR_LEAD : '0;
            state_nxt = ST_TMR_RUNNING;
          end
          CLR_BUTTON: begin
            if (ctl.button) state_nxt = rec ? ST_BTN_CLEARED : ST_CLEARED;
          end
          default: ;
        endcase
      end
      ST_BTN_CLEARED, ST_TMR_DONE: begin
        if (!trig) state_nxt = ST_INACTIVE;
      end
      ST_TMR_RUNNING: begin
        if (timer_r <= TMR_STEP) begin
          timer_nxt = '0;
          state_nxt = rec ? ST_TMR_DONE : ST_CLEARED;
        end else begin
          timer_nxt = timer_r - TMR_STEP;
        end
      end
      default: ;
    endcase
  end

  // Display request of this message during the tick.
  always_comb begin
    show = 1'b0;
    unique case (state_r)
      ST_INACTIVE:    show = allowed && trig;
      ST_ACTIVE: begin
        case (mode)
          CLR_TRIGGER: show = trig;
          CLR_TIMEOUT: show = 1'b1;
          CLR_BUTTON:  show = !ctl.button;
          default:     show = 1'b0;
        endcase
      end
      ST_TMR_RUNNING: show = (timer_r > TMR_STEP);
      default:        show = 1'b0;
    endcase
  end

  // Message state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INACTIVE;
    end else if (ctl.clear_all) begin
      state_r <= ST_INACTIVE;
    end else if (ctl.step) begin
      state_r <= state_nxt;
    end
  end

  // Countdown timer; only read after it has been loaded.
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      timer_r <= timer_nxt;
    end
  end

endmodule

// ===== hdl/wmpm_merge.sv =====
module wmpm_merge
  import wmpm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [MESSAGES-1:0] show,
  output merge_res_t          res
);

  logic              shown_valid_r, shown_valid_nxt;
  logic [SLOT_W-1:0] shown_slot_r, shown_slot_nxt;
  logic              found;
  logic [SLOT_W-1:0] pick;
  logic              changed;

  // Lowest-index lane that asks for display wins.
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int m = MESSAGES - 1; m >= 0; m--) begin
      if (show[m]) begin
        found = 1'b1;
        pick  = SLOT_W'(m);
      end
    end
  end

  // Change detection against the message shown before this tick.
  always_comb begin
    changed         = step && ((found != shown_valid_r) ||
                               (found && (pick != shown_slot_r)));
    shown_valid_nxt = changed ? found : shown_valid_r;
    shown_slot_nxt  = changed ? (found ? pick : '0) : shown_slot_r;
  end

  assign res.valid   = shown_valid_nxt;
  assign res.slot    = shown_slot_nxt;
  assign res.changed = changed;

  // Shown message register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_valid_r <= 1'b0;
      shown_slot_r  <= '0;
    end else begin
      shown_valid_r <= shown_valid_nxt;
      shown_slot_r  <= shown_slot_nxt;
    end
  end

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import wmpm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int SETTLE_CYCLES  = 4;

  // One tick request and the display state that it produces.
  typedef struct packed {
    logic              ignition_on;
    logic signed [3:0] layout_id;
    logic [7:0]        trigger_mask;
    logic              clear_button;
  } tick_t;

  typedef struct packed {
    logic              showing;
    logic [SLOT_W-1:0] shown_index;
    logic              display_changed;
    logic              running;
  } display_t;

  logic clk;
  logic rst_n;

  wmpm_in_if  in_ch();
  wmpm_out_if out_ch();
  wmpm_cfg_if cfg_ch();

  warning_message_priority_manager_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted copy of the registers and of the message state.
  logic [15:0]        clear_modes_q;
  logic [7:0]         recurring_q;
  logic [63:0]        timeouts_lo_q;
  logic [63:0]        timeouts_hi_q;
  logic [63:0]        layout_allow_q;
  logic               run_q;
  msg_state_t         msg_state_q [MESSAGES];
  logic [TIMER_W-1:0] msg_timer_q [MESSAGES];
  logic               shown_valid_q;
  logic [SLOT_W-1:0]  shown_slot_q;

  tick_t    pending_ticks [$];
  display_t expected_displays [$];
  tick_t    sent_tick;
  int       ticks_outstanding;
  int       in_gap;
  int       out_stall;
  int       quiet_cycles;
  int       mismatches;
  bit       calm;

  // State of the well-formed random sequence.
  bit         held_ign;
  int         held_layout;
  logic [7:0] held_trig;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advances the predicted block by one tick and returns the display it reports.
  function automatic display_t advance_tick(tick_t t);
    display_t           d;
    logic               found;
    logic               show;
    logic               rec;
    logic               no_layout;
    logic               trig;
    logic [SLOT_W-1:0]  pick;
    logic [3:0]         mag;
    logic [TIMER_W-1:0] limit;
    clr_mode_t          mode;
    found = 1'b0;
    pick = '0;
    d.display_changed = 1'b0;
    if (!run_q) begin
      if (t.ignition_on) begin
        for (int m = 0; m < MESSAGES; m++) msg_state_q[m] = ST_INACTIVE;
        run_q = 1'b1;
      end
    end else if (!t.ignition_on) begin
      run_q = 1'b0;
    end else begin
      no_layout = (t.layout_id == LAYOUT_NONE);
      mag = t.layout_id[3] ? 4'(-t.layout_id) : t.layout_id;
      for (int m = 0; m < MESSAGES; m++) begin
        show = 1'b0;
        trig = t.trigger_mask[m];
        rec = recurring_q[m];
        mode = clr_mode_t'(clear_modes_q[2*m +: 2]);
        case (msg_state_q[m])
          ST_INACTIVE: begin
            if (!no_layout && mag < LAYOUTS && layout_allow_q[8*m + mag[2:0]] && trig) begin
              msg_state_q[m] = ST_ACTIVE;
              show = 1'b1;
            end
          end
          ST_ACTIVE: begin
            case (mode)
              CLR_TRIGGER: begin
                if (trig) show = 1'b1;
                else msg_state_q[m] = ST_INACTIVE;
              end
              CLR_TIMEOUT: begin
                limit = (m < 4) ? timeouts_lo_q[16*(m%4) +: 16] : timeouts_hi_q[16*(m%4) +: 16];
                show = 1'b1;
                msg_timer_q[m] = (limit > TMR_LEAD) ? limit - TMR_LEAD : '0;
                msg_state_q[m] = ST_TMR_RUNNING;
              end
              CLR_BUTTON: begin
                if (t.clear_button) msg_state_q[m] = rec ? ST_BTN_CLEARED : ST_CLEARED;
                else show = 1'b1;
              end
              CLR_NONE: ;
            endcase
          end
          ST_BTN_CLEARED, ST_TMR_DONE: begin
            if (!trig) msg_state_q[m] = ST_INACTIVE;
          end
          ST_TMR_RUNNING: begin
            if (msg_timer_q[m] <= TMR_STEP) begin
              msg_timer_q[m] = '0;
              msg_state_q[m] = rec ? ST_TMR_DONE : ST_CLEARED;
            end else begin
              show = 1'b1;
              msg_timer_q[m] = msg_timer_q[m] - TMR_STEP;
            end
          end
          default: ;
        endcase
        if (show && !found) begin
          found = 1'b1;
          pick = SLOT_W'(m);
        end
      end
      if (found != shown_valid_q || (found && pick != shown_slot_q)) begin
        d.display_changed = 1'b1;
        shown_valid_q = found;
        shown_slot_q = found ? pick : '0;
      end
    end
    d.showing = shown_valid_q;
    d.shown_index = shown_valid_q ? shown_slot_q : '0;
    d.running = run_q;
    return d;
  endfunction

  // Gap length: mostly none or short, now and then long; none in calm phases.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Random timeouts, some of them near or below the timer lead so that it saturates.
  function automatic logic [63:0] random_timeouts(int hi);
    logic [63:0] v;
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 9) < 3) v[16*k +: 16] = 16'($urandom_range(0, 40));
      else v[16*k +: 16] = 16'($urandom_range(41, hi));
    end
    return v;
  endfunction

  function automatic logic [63:0] random_allow();
    return {$urandom, $urandom} | {$urandom, $urandom};
  endfunction

  function automatic void queue_tick(bit ign, int lay, logic [7:0] trig, bit btn);
    tick_t t;
    t.ignition_on = ign;
    t.layout_id = 4'(lay);
    t.trigger_mask = trig;
    t.clear_button = btn;
    pending_ticks.push_back(t);
  endfunction

  // Request driver.
  always @(posedge clk) begin
    tick_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) expected_displays.push_back(advance_tick(sent_tick));
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          nxt = pending_ticks.pop_front();
          sent_tick = nxt;
          ticks_outstanding++;
          in_ch.valid <= 1'b1;
          in_ch.ignition_on <= nxt.ignition_on;
          in_ch.layout_id <= nxt.layout_id;
          in_ch.trigger_mask <= nxt.trigger_mask;
          in_ch.clear_button <= nxt.clear_button;
          in_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    display_t got;
    display_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.showing = out_ch.showing;
        got.shown_index = out_ch.shown_index;
        got.display_changed = out_ch.display_changed;
        got.running = out_ch.running;
        if (expected_displays.size() == 0) begin
          flag_error($sformatf("unexpected result: showing=%0b index=%0d changed=%0b running=%0b",
                               got.showing, got.shown_index, got.display_changed, got.running));
        end else begin
          want = expected_displays.pop_front();
          ticks_outstanding--;
          if (got.showing !== want.showing || got.shown_index !== want.shown_index ||
              got.display_changed !== want.display_changed || got.running !== want.running) begin
            flag_error($sformatf({"result mismatch: expected showing=%0b index=%0d changed=%0b ",
                                  "running=%0b, got showing=%0b index=%0d changed=%0b running=%0b"},
                                 want.showing, want.shown_index, want.display_changed,
                                 want.running, got.showing, got.shown_index,
                                 got.display_changed, got.running));
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_stall = pick_gap();
      end
    end
  end

  // Watchdog: ends the run when no request moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Writes one register and mirrors it once the request is taken.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_CLEAR_MODES:    clear_modes_q = value[15:0];
      CFG_RECURRING_MASK: recurring_q = value[7:0];
      CFG_TIMEOUTS_LOW:   timeouts_lo_q = value;
      CFG_TIMEOUTS_HIGH:  timeouts_hi_q = value;
      CFG_LAYOUT_ALLOW:   layout_allow_q = value;
      default: ;
    endcase
  endtask

  task automatic write_setup(logic [15:0] modes, logic [7:0] recur, logic [63:0] lo,
                             logic [63:0] hi, logic [63:0] allow);
    write_reg(CFG_CLEAR_MODES, CFG_DATA_W'(modes));
    write_reg(CFG_RECURRING_MASK, CFG_DATA_W'(recur));
    write_reg(CFG_TIMEOUTS_LOW, lo);
    write_reg(CFG_TIMEOUTS_HIGH, hi);
    write_reg(CFG_LAYOUT_ALLOW, allow);
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || ticks_outstanding != 0) @(posedge clk);
  endtask

  // Mostly held triggers and layouts with occasional changes, plus some noise.
  task automatic queue_random_ticks(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        queue_tick($urandom_range(0, 1), int'($urandom_range(0, 15)) - 8, 8'($urandom),
                   $urandom_range(0, 1));
      end else begin
        if (held_ign) begin
          if ($urandom_range(0, 99) < 2) held_ign = 1'b0;
        end else if ($urandom_range(0, 99) < 35) begin
          held_ign = 1'b1;
        end
        if ($urandom_range(0, 99) < 6) begin
          r = $urandom_range(0, 9);
          if (r < 8) held_layout = $urandom_range(0, 7);
          else if (r == 8) held_layout = -1;
          else held_layout = int'($urandom_range(0, 15)) - 8;
        end
        for (int b = 0; b < 8; b++) begin
          if ($urandom_range(0, 99) < 7) held_trig[b] = ~held_trig[b];
        end
        if ($urandom_range(0, 99) < 4) held_trig = 8'($urandom);
        queue_tick(held_ign, held_layout, held_trig, $urandom_range(0, 99) < 12);
      end
    end
  endtask

  task automatic random_setup();
    write_setup(16'($urandom), 8'($urandom), random_timeouts(150), random_timeouts(150),
                random_allow());
  endtask

  // Reset, then the directed phase and the random phases.
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.ignition_on = 1'b0;
    in_ch.layout_id = '0;
    in_ch.trigger_mask = '0;
    in_ch.clear_button = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_CLEAR_MODES;
    cfg_ch.data = '0;
    clear_modes_q = '0;
    recurring_q = '0;
    timeouts_lo_q = '0;
    timeouts_hi_q = '0;
    layout_allow_q = '0;
    run_q = 1'b0;
    for (int m = 0; m < MESSAGES; m++) begin
      msg_state_q[m] = ST_INACTIVE;
      msg_timer_q[m] = '0;
    end
    shown_valid_q = 1'b0;
    shown_slot_q = '0;
    ticks_outstanding = 0;
    in_gap = 0;
    out_stall = 0;
    quiet_cycles = 0;
    mismatches = 0;
    calm = 1'b0;
    held_ign = 1'b1;
    held_layout = 0;
    held_trig = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Every clear mode twice over, upper half recurring, message 1 with a zero
    // timeout and message 5 with a short one; each message barred from its own layout.
    write_setup(16'hE4E4, 8'hF0, 64'h0, 64'h0000_0000_002D_0000, 64'h7FBF_DFEF_F7FB_FDFE);
    queue_tick(0, 0, 8'hFF, 0);     // stays off
    queue_tick(1, 0, 8'hFF, 0);     // off to run, nothing processed
    queue_tick(1, 2, 8'hFF, 0);     // activation in every allowed slot
    queue_tick(1, 2, 8'hFF, 0);     // timers start, one saturates at zero
    queue_tick(1, 2, 8'hFE, 1);     // trigger drop and button clear
    queue_tick(1, -1, 8'hBE, 0);    // no layout
    queue_tick(1, -8, 8'hFF, 0);    // magnitude eight is never allowed
    queue_tick(1, 7, 8'h00, 0);     // all triggers low, nothing shown
    queue_tick(1, -7, 8'hFF, 0);    // negative layout uses its magnitude
    queue_tick(1, -7, 8'hFF, 1);
    queue_tick(0, -7, 8'hFF, 1);    // run to off
    queue_tick(0, 3, 8'h00, 0);
    queue_tick(1, 3, 8'hFF, 0);     // off to run clears latched messages
    for (int i = 0; i < 6; i++) queue_tick(1, 3, 8'h20, 0);  // countdown to timeout
    queue_tick(1, 3, 8'h00, 0);     // recurring message re-arms
    queue_tick(1, 3, 8'h20, 1);
    queue_tick(1, -2, 8'h55, 1);
    queue_tick(1, -1, 8'hFF, 1);
    queue_tick(0, -1, 8'h00, 0);
    wait_drained();

    random_setup();
    queue_random_ticks(250);
    wait_drained();

    // All clear by trigger, zero timeouts, every layout allowed, no idling.
    write_setup(16'h0000, 8'h00, 64'h0, 64'h0, '1);
    calm = 1'b1;
    queue_random_ticks(120);
    wait_drained();
    calm = 1'b0;

    // Nothing ever clears, every message recurring, largest timeouts.
    write_setup(16'hFFFF, 8'hFF, '1, '1, '1);
    queue_random_ticks(60);
    wait_drained();

    // All clear by timeout, longest timeouts on the lower-priority half.
    write_setup(16'h5555, 8'($urandom), random_timeouts(150), '1, random_allow());
    queue_random_ticks(120);
    wait_drained();

    random_setup();
    queue_random_ticks(370);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_displays.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_displays.size()));
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
